// ----- hdl/sfrp_pkg.sv -----
// ----------------------------------------------------------------------------
// sfrp_pkg: shared types and constants of the serial frame receive parser
// Frame marker characters, result codes, controller states and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sfrp_pkg;

    localparam int InbufBytesDefault = 64;
    localparam int HdrBytes          = 5;

    localparam int ByteW  = 8;
    localparam int EventW = 3;
    localparam int PtypeW = 2;
    localparam int SizeW  = 6;

    localparam int InTdataW  = 8;
    localparam int OutTdataW = 32;
    localparam int OutTuserW = 7;

    localparam logic [ByteW-1:0] CharDollar = 8'h24;
    localparam logic [ByteW-1:0] CharM      = 8'h4D;
    localparam logic [ByteW-1:0] CharLt     = 8'h3C;
    localparam logic [ByteW-1:0] CharGt     = 8'h3E;
    localparam logic [ByteW-1:0] CharBang   = 8'h21;

    localparam logic [EventW-1:0] EvNone      = 3'd0;
    localparam logic [EventW-1:0] EvFrameOk   = 3'd1;
    localparam logic [EventW-1:0] EvChecksum  = 3'd2;
    localparam logic [EventW-1:0] EvTooLong   = 3'd3;
    localparam logic [EventW-1:0] EvBadHeader = 3'd4;

    localparam logic [PtypeW-1:0] PtCommand = 2'd0;
    localparam logic [PtypeW-1:0] PtReply   = 2'd1;
    localparam logic [PtypeW-1:0] PtError   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GOT_DOLLAR,
        ST_GOT_M,
        ST_WANT_SIZE,
        ST_WANT_CMD,
        ST_REJECT_CMD,
        ST_PAYLOAD,
        ST_CHECKSUM,
        ST_RD_ADDR,
        ST_RD_EMIT
    } t_state;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_SIMPLE,
        EM_OK_EMPTY,
        EM_PAYLOAD
    } t_emit;

    typedef struct packed {
        logic              clr_frame;
        logic              ld_type;
        logic              ld_len;
        logic              xor_en;
        logic              ld_cmd;
        logic              wr_payload;
        logic              rd_start;
        logic              rd_issue;
        logic              rd_next;
        t_emit             emit;
        logic              consumed;
        logic [EventW-1:0] event_res;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_dollar;
        logic is_m;
        logic dir_valid;
        logic size_too_big;
        logic xor_match;
        logic len_zero;
        logic count_last;
        logic rd_last;
        logic out_free;
    } t_dp_status;

    function automatic logic [PtypeW-1:0] dir_to_type(input logic [ByteW-1:0] c);
        logic [PtypeW-1:0] t;
        t = PtCommand;
        if (c == CharGt) begin
            t = PtReply;
        end else if (c == CharBang) begin
            t = PtError;
        end
        return t;
    endfunction

endpackage

// ----- hdl/serial_frame_receive_parser_unit.sv -----
// ----------------------------------------------------------------------------
// serial_frame_receive_parser_unit: serial frame receive parser
// Recognizes '$','M',direction,size,command,payload,checksum frames in a
// byte stream, buffers the payload and reads it out after a good checksum.
//
//   Channel   Dir  Beat                 Content
//   s_axis    in   one received byte    tdata: in_byte
//   m_axis    out  one result           tdata/tuser/tlast: see port comments
//
// A byte is taken whenever the result register is free or is being emptied.
// After a good checksum on a non-empty frame, input is held off while the
// payload buffer is read out, each payload byte by a buffer read and then a
// result load. Reset is synchronous and needs no clearing pass.
// Stalls on m_axis hold the result and back up into s_axis tready.
// ----------------------------------------------------------------------------
module serial_frame_receive_parser_unit #(
    parameter int INBUF_BYTES = sfrp_pkg::InbufBytesDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [7:0] in_byte
    input  logic [sfrp_pkg::InTdataW-1:0]  i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [7:0] command, [13:8] data_size, [21:14] payload_byte,
    // [27:22] payload_index, [31:28] zero
    output logic [sfrp_pkg::OutTdataW-1:0] o_m_axis_tdata,
    // [0] consumed, [3:1] event_res, [5:4] packet_type, [6] payload_valid
    output logic [sfrp_pkg::OutTuserW-1:0] o_m_axis_tuser,
    // last
    output logic                           o_m_axis_tlast
);
    import sfrp_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    sfrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sfrp_dp #(
        .INBUF_BYTES (INBUF_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_byte     (i_s_axis_tdata[ByteW-1:0]),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule

// ----- hdl/sfrp_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfrp_ctrl: frame parser controller
// Walks through the header, payload and checksum of a frame one beat at a
// time and sequences the payload readout after a good checksum.
// ----------------------------------------------------------------------------
module sfrp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  sfrp_pkg::t_dp_status i_status,
    output sfrp_pkg::t_ctrl_cmd  o_cmd
);
    import sfrp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_parse;
    logic   acc;

    always_comb begin
        in_parse = (r_state != ST_RD_ADDR) && (r_state != ST_RD_EMIT);
    end

    assign o_s_tready = in_parse && i_status.out_free;
    assign acc        = o_s_tready && i_s_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && i_status.is_dollar) n_state = ST_GOT_DOLLAR;
            end
            ST_GOT_DOLLAR: begin
                if (acc) n_state = i_status.is_m ? ST_GOT_M : ST_IDLE;
            end
            ST_GOT_M: begin
                if (acc) n_state = i_status.dir_valid ? ST_WANT_SIZE : ST_IDLE;
            end
            ST_WANT_SIZE: begin
                if (acc) n_state = i_status.size_too_big ? ST_REJECT_CMD : ST_WANT_CMD;
            end
            ST_REJECT_CMD: begin
                if (acc) n_state = ST_IDLE;
            end
            ST_WANT_CMD: begin
                if (acc) n_state = i_status.len_zero ? ST_CHECKSUM : ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                if (acc && i_status.count_last) n_state = ST_CHECKSUM;
            end
            ST_CHECKSUM: begin
                if (acc) begin
                    n_state = (i_status.xor_match && !i_status.len_zero) ? ST_RD_ADDR
                                                                          : ST_IDLE;
                end
            end
            ST_RD_ADDR: begin
                n_state = ST_RD_EMIT;
            end
            ST_RD_EMIT: begin
                if (i_status.out_free) n_state = i_status.rd_last ? ST_IDLE : ST_RD_ADDR;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd           = '0;
        o_cmd.emit      = EM_NONE;
        o_cmd.event_res = EvNone;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    o_cmd.emit      = EM_SIMPLE;
                    o_cmd.consumed  = i_status.is_dollar;
                    o_cmd.clr_frame = i_status.is_dollar;
                end
            end
            ST_GOT_DOLLAR: begin
                if (acc) begin
                    o_cmd.emit      = EM_SIMPLE;
                    o_cmd.consumed  = 1'b1;
                    o_cmd.event_res = i_status.is_m ? EvNone : EvBadHeader;
                end
            end
            ST_GOT_M: begin
                if (acc) begin
                    o_cmd.emit      = EM_SIMPLE;
                    o_cmd.consumed  = 1'b1;
                    o_cmd.ld_type   = i_status.dir_valid;
                    o_cmd.event_res = i_status.dir_valid ? EvNone : EvBadHeader;
                end
            end
            ST_WANT_SIZE: begin
                if (acc) begin
                    o_cmd.emit     = EM_SIMPLE;
                    o_cmd.consumed = 1'b1;
                    o_cmd.xor_en   = 1'b1;
                    o_cmd.ld_len   = !i_status.size_too_big;
                end
            end
            ST_REJECT_CMD: begin
                if (acc) begin
                    o_cmd.emit      = EM_SIMPLE;
                    o_cmd.consumed  = 1'b1;
                    o_cmd.event_res = EvTooLong;
                end
            end
            ST_WANT_CMD: begin
                if (acc) begin
                    o_cmd.emit     = EM_SIMPLE;
                    o_cmd.consumed = 1'b1;
                    o_cmd.xor_en   = 1'b1;
                    o_cmd.ld_cmd   = 1'b1;
                end
            end
            ST_PAYLOAD: begin
                if (acc) begin
                    o_cmd.emit       = EM_SIMPLE;
                    o_cmd.consumed   = 1'b1;
                    o_cmd.xor_en     = 1'b1;
                    o_cmd.wr_payload = 1'b1;
                end
            end
            ST_CHECKSUM: begin
                if (acc) begin
                    o_cmd.consumed = 1'b1;
                    if (!i_status.xor_match) begin
                        o_cmd.emit      = EM_SIMPLE;
                        o_cmd.event_res = EvChecksum;
                    end else if (i_status.len_zero) begin
                        o_cmd.emit = EM_OK_EMPTY;
                    end else begin
                        // The payload run is emitted by the readout states.
                        o_cmd.rd_start = 1'b1;
                    end
                end
            end
            ST_RD_ADDR: begin
                o_cmd.rd_issue = 1'b1;
            end
            ST_RD_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit    = EM_PAYLOAD;
                    o_cmd.rd_next = 1'b1;
                end
            end
            default: begin
                o_cmd.emit = EM_NONE;
            end
        endcase
    end

endmodule

// ----- hdl/sfrp_dp.sv -----
// ----------------------------------------------------------------------------
// sfrp_dp: frame parser datapath
// Holds the frame registers, the running checksum, the payload buffer and
// the result register that drives the master-side stream.
// ----------------------------------------------------------------------------
module sfrp_dp #(
    parameter int INBUF_BYTES = sfrp_pkg::InbufBytesDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sfrp_pkg::t_ctrl_cmd            i_cmd,
    output sfrp_pkg::t_dp_status           o_status,
    input  logic [sfrp_pkg::ByteW-1:0]     i_byte,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [sfrp_pkg::OutTdataW-1:0] o_m_tdata,
    output logic [sfrp_pkg::OutTuserW-1:0] o_m_tuser,
    output logic                           o_m_tlast
);
    import sfrp_pkg::*;

    localparam int PayloadMax = INBUF_BYTES - HdrBytes;
    localparam int AddrW      = (PayloadMax > 1) ? $clog2(PayloadMax) : 1;

    logic [ByteW-1:0]  r_xor;
    logic [PtypeW-1:0] r_ftype;
    logic [ByteW-1:0]  r_fcmd;
    logic [SizeW-1:0]  r_flen;
    logic [SizeW-1:0]  r_byte_count;
    logic [SizeW-1:0]  r_rd_idx;
    logic [ByteW-1:0]  r_rd_data;
    logic [ByteW-1:0]  r_mem [PayloadMax];

    logic              r_out_valid;
    logic              r_o_consumed;
    logic [EventW-1:0] r_o_event;
    logic [PtypeW-1:0] r_o_ptype;
    logic [ByteW-1:0]  r_o_cmd;
    logic [SizeW-1:0]  r_o_size;
    logic [ByteW-1:0]  r_o_byte;
    logic [SizeW-1:0]  r_o_idx;
    logic              r_o_pvalid;
    logic              r_o_last;

    logic out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        o_status.is_dollar    = (i_byte == CharDollar);
        o_status.is_m         = (i_byte == CharM);
        o_status.dir_valid    = (i_byte == CharLt) || (i_byte == CharGt)
                                || (i_byte == CharBang);
        o_status.size_too_big = (i_byte > ByteW'(PayloadMax));
        o_status.xor_match    = (r_xor == i_byte);
        o_status.len_zero     = (r_flen == '0);
        o_status.count_last   = ((7'(r_byte_count) + 7'd1) >= {1'b0, r_flen});
        o_status.rd_last      = ((7'(r_rd_idx) + 7'd1) == {1'b0, r_flen});
        o_status.out_free     = out_free;
    end

    // Frame registers and checksum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor        <= '0;
            r_byte_count <= '0;
            r_rd_idx     <= '0;
        end else begin
            if (i_cmd.clr_frame) begin
                r_xor        <= '0;
                r_byte_count <= '0;
            end else if (i_cmd.xor_en) begin
                r_xor <= r_xor ^ i_byte;
            end
            if (i_cmd.ld_cmd) begin
                r_byte_count <= '0;
            end else if (i_cmd.wr_payload) begin
                r_byte_count <= r_byte_count + SizeW'(1);
            end
            if (i_cmd.rd_start) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd_next) begin
                r_rd_idx <= r_rd_idx + SizeW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_type) r_ftype <= dir_to_type(i_byte);
        if (i_cmd.ld_len)  r_flen  <= i_byte[SizeW-1:0];
        if (i_cmd.ld_cmd)  r_fcmd  <= i_byte;
    end

    // Payload buffer: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_payload) begin
            r_mem[r_byte_count[AddrW-1:0]] <= i_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_rd_idx[AddrW-1:0]];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit != EM_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.emit)
            EM_SIMPLE: begin
                r_o_consumed <= i_cmd.consumed;
                r_o_event    <= i_cmd.event_res;
                r_o_ptype    <= PtCommand;
                r_o_cmd      <= '0;
                r_o_size     <= '0;
                r_o_byte     <= '0;
                r_o_idx      <= '0;
                r_o_pvalid   <= 1'b0;
                r_o_last     <= 1'b1;
            end
            EM_OK_EMPTY: begin
                r_o_consumed <= 1'b1;
                r_o_event    <= EvFrameOk;
                r_o_ptype    <= r_ftype;
                r_o_cmd      <= r_fcmd;
                r_o_size     <= '0;
                r_o_byte     <= '0;
                r_o_idx      <= '0;
                r_o_pvalid   <= 1'b0;
                r_o_last     <= 1'b1;
            end
            EM_PAYLOAD: begin
                r_o_consumed <= 1'b1;
                r_o_event    <= EvFrameOk;
                r_o_ptype    <= r_ftype;
                r_o_cmd      <= r_fcmd;
                r_o_size     <= r_flen;
                r_o_byte     <= r_rd_data;
                r_o_idx      <= r_rd_idx;
                r_o_pvalid   <= 1'b1;
                r_o_last     <= o_status.rd_last;
            end
            EM_NONE: begin
                r_o_last <= r_o_last;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_o_idx, r_o_byte, r_o_size, r_o_cmd};
    assign o_m_tuser  = {r_o_pvalid, r_o_ptype, r_o_event, r_o_consumed};
    assign o_m_tlast  = r_o_last;

endmodule
